// ===== hw/rtl/length_prefixed_deframer_macros.svh =====
// assertion macros for the length-prefixed deframer
`ifndef LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define LPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("deframer assertion failed");
// expression must never be true outside reset
`define LPD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("deframer forbidden condition seen");
`else
`define LPD_ASSERT(lbl, clk, rst_n, prop)
`define LPD_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== hw/rtl/lpd_pkg.sv =====
// shared types and constants of the length-prefixed deframer
package lpd_pkg;

  // header and frame sizes
  localparam int unsigned HdrBytes   = 4;
  localparam logic [31:0] HdrLen     = 32'd4;
  localparam logic [31:0] KeepMinLen = 32'd8;

  // result queue geometry
  localparam int unsigned QDepth = 8;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);
  localparam int unsigned PushW  = $clog2(HdrBytes + 1);

  // parser phase codes
  localparam logic [1:0] PhHunt = 2'd0;
  localparam logic [1:0] PhPass = 2'd1;
  localparam logic [1:0] PhSkip = 2'd2;
  localparam logic [1:0] PhDrop = 2'd3;

  // one result entry
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        frame_last;
    logic [31:0] frame_length;
  } lpd_res_t;

endpackage

// ===== hw/rtl/lpd_in_if.sv =====
// byte stream channel into the deframer
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_last;

  modport source (output valid, output data_byte, output chunk_last, input ready);
  modport sink   (input valid, input data_byte, input chunk_last, output ready);
endinterface

// ===== hw/rtl/lpd_out_if.sv =====
// kept frame byte channel out of the deframer
interface lpd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        frame_last;
  logic [31:0] frame_length;

  modport source (output valid, output out_byte, output frame_last, output frame_length,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_last, input frame_length,
                  output ready);
endinterface

// ===== hw/rtl/length_prefixed_deframer.sv =====
// length-prefixed deframer top level: header parser and result queue
//
// in_i carries one stream byte per request with chunk_last marking the end of
// a received chunk. Each frame starts with a 4-byte big-endian length that
// counts the whole frame. Frames longer than 8 bytes leave on out_o whole,
// header included, one byte per request with frame_last on the final byte and
// the frame length alongside. Shorter frames and the rest of a chunk after a
// zero length are consumed without output.
// Throughput: one input byte per cycle while in_i.ready is high. The parser
// updates its state in the accepting cycle and pushes 0, 1 or 4 results into
// an 8-entry queue; header byte four pushes all four header bytes at once.
// A result is registered into the queue by the request that caused it and is
// visible on out_o in the cycle after, behind any results already queued.
// in_i.ready is high while the queue holds at most 4 results, so a receiver
// that stalls fills the queue and then holds off the input; nothing is lost.
// A kept frame's header burst drains while the body bytes arrive, so a
// receiver taking one byte per cycle never stalls the input.
// Reset empties the queue and puts the parser into header hunt with all
// counters cleared.
`include "length_prefixed_deframer_macros.svh"

module length_prefixed_deframer (
  input logic            clk_i,
  input logic            rst_ni,
  lpd_in_if.sink         in_i,
  lpd_out_if.source      out_o
);
  import lpd_pkg::*;

  logic [31:0]     header_shift_q, header_shift_d;
  logic [2:0]      header_count_q, header_count_d;
  logic [31:0]     bytes_left_q, bytes_left_d;
  logic [31:0]     current_length_q, current_length_d;
  logic [1:0]      phase_q, phase_d;

  lpd_res_t        queue_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  lpd_res_t        res [HdrBytes];
  logic [PushW-1:0] push_n;
  logic            in_acc, out_acc;
  logic [31:0]     shift_next, left_dec;

  assign in_acc  = in_i.valid & in_i.ready;
  assign out_acc = out_o.valid & out_o.ready;

  // accept while the queue has room for a full header burst
  assign in_i.ready = (cnt_q <= CntW'(QDepth - HdrBytes));

  assign shift_next = {header_shift_q[23:0], in_i.data_byte};
  assign left_dec   = bytes_left_q - 32'd1;

  // parser next state and results
  always_comb begin
    header_shift_d   = header_shift_q;
    header_count_d   = header_count_q;
    bytes_left_d     = bytes_left_q;
    current_length_d = current_length_q;
    phase_d          = phase_q;
    push_n           = '0;
    for (int i = 0; i < HdrBytes; i++) begin
      res[i].out_byte     = shift_next[8*(HdrBytes-1-i) +: 8];
      res[i].frame_last   = 1'b0;
      res[i].frame_length = shift_next;
    end
    if (in_acc) begin
      case (phase_q)
        PhHunt: begin
          header_shift_d = shift_next;
          if (header_count_q < 3'd3) begin
            header_count_d = header_count_q + 3'd1;
          end else begin
            header_count_d   = '0;
            current_length_d = shift_next;
            if (shift_next == '0) begin
              phase_d = in_i.chunk_last ? PhHunt : PhDrop;
            end else if (shift_next <= HdrLen) begin
              phase_d = PhHunt;
            end else if (shift_next <= KeepMinLen) begin
              bytes_left_d = shift_next - HdrLen;
              phase_d      = PhSkip;
            end else begin
              bytes_left_d = shift_next - HdrLen;
              push_n       = PushW'(HdrBytes);
              phase_d      = PhPass;
            end
          end
        end
        PhPass: begin
          bytes_left_d        = left_dec;
          res[0].out_byte     = in_i.data_byte;
          res[0].frame_last   = (left_dec == '0);
          res[0].frame_length = current_length_q;
          push_n              = PushW'(1);
          if (left_dec == '0) begin
            phase_d = PhHunt;
          end
        end
        PhSkip: begin
          bytes_left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PhHunt;
          end
        end
        default: begin
          if (in_i.chunk_last) begin
            phase_d = PhHunt;
          end
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_shift_q   <= '0;
      header_count_q   <= '0;
      bytes_left_q     <= '0;
      current_length_q <= '0;
      phase_q          <= PhHunt;
    end else begin
      header_shift_q   <= header_shift_d;
      header_count_q   <= header_count_d;
      bytes_left_q     <= bytes_left_d;
      current_length_q <= current_length_d;
      phase_q          <= phase_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HdrBytes; i++) begin
      if (PushW'(i) < push_n) begin
        queue_q[PtrW'(wr_ptr_q + PtrW'(i))] <= res[i];
      end
    end
  end

  // result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= PtrW'(wr_ptr_q + PtrW'(push_n));
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= CntW'(cnt_q + CntW'(push_n) - CntW'(out_acc));
    end
  end

  // output side
  assign out_o.valid        = (cnt_q != '0);
  assign out_o.out_byte     = queue_q[rd_ptr_q].out_byte;
  assign out_o.frame_last   = queue_q[rd_ptr_q].frame_last;
  assign out_o.frame_length = queue_q[rd_ptr_q].frame_length;

  // checks
  `LPD_ASSERT_NEVER(a_queue_over, clk_i, rst_ni, cnt_q > CntW'(QDepth))
  `LPD_ASSERT(a_pass_len, clk_i, rst_ni, (phase_q == PhPass) |-> (current_length_q > KeepMinLen))
  `LPD_ASSERT(a_body_left, clk_i, rst_ni,
    ((phase_q == PhPass) || (phase_q == PhSkip)) |-> (bytes_left_q != '0))
  `LPD_ASSERT(a_hdr_push, clk_i, rst_ni,
    (in_acc && (phase_q == PhHunt) && (phase_d == PhPass)) |=> (cnt_q >= CntW'(HdrBytes - 1)))

endmodule

// ===== bench/length_prefixed_deframer_test.sv =====
// self-checking testbench for the length-prefixed deframer: framed byte stream in, kept bytes checked
module length_prefixed_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpd_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned LongStall = 60;
  localparam int unsigned StallEvery = 120;
  localparam int unsigned PauseEvery = 110;
  localparam int unsigned StreamTarget = 470;
  localparam int unsigned SettleCycles = 8;

  // one pending stream byte, optionally held back until all kept bytes are out
  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
    logic       drain_first;
  } stream_req_t;

  // parser state mirrored from the block
  typedef struct {
    logic [31:0] shift;
    logic [2:0]  count;
    logic [31:0] left;
    logic [31:0] length;
    logic [1:0]  phase;
  } parser_state_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lpd_in_if  in_if ();
  lpd_out_if out_if ();

  length_prefixed_deframer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  stream_req_t   stream_backlog[$];
  lpd_res_t      kept_bytes_due[$];
  parser_state_t parser;

  logic        pause_before_next = 1'b0;
  int unsigned stream_count = 0;
  int unsigned next_pause = 0;
  int unsigned pick;
  int unsigned error_count = 0;
  int unsigned bytes_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned frames_kept = 0;
  int unsigned frames_consumed = 0;
  int unsigned frames_short = 0;
  int unsigned frames_zero = 0;

  // sender and receiver pacing
  logic        offering;
  stream_req_t req_now;
  int unsigned burst_left;
  int unsigned gap_left;
  logic        take;
  lpd_res_t    want;
  int unsigned hold_left;
  int unsigned next_long_stall;
  int unsigned pattern_cycle;
  int unsigned idle_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected kept bytes for one accepted stream byte
  function automatic void deframe_byte(input logic [7:0] b, input logic clast);
    case (parser.phase)
      PhHunt: begin
        parser.shift = {parser.shift[23:0], b};
        if (parser.count < 3'd3) begin
          parser.count = parser.count + 3'd1;
        end else begin
          parser.count  = 3'd0;
          parser.length = parser.shift;
          if (parser.length == 32'd0) begin
            frames_zero++;
            parser.phase = clast ? PhHunt : PhDrop;
          end else if (parser.length <= HdrLen) begin
            frames_short++;
            parser.phase = PhHunt;
          end else if (parser.length <= KeepMinLen) begin
            frames_consumed++;
            parser.left  = parser.length - HdrLen;
            parser.phase = PhSkip;
          end else begin
            // whole header goes out at once, msb first
            frames_kept++;
            parser.left = parser.length - HdrLen;
            for (int k = 0; k < 4; k++) begin
              kept_bytes_due.push_back('{out_byte: parser.shift[31-8*k -: 8], frame_last: 1'b0,
                                         frame_length: parser.length});
            end
            parser.phase = PhPass;
          end
        end
      end
      PhPass: begin
        parser.left = parser.left - 32'd1;
        kept_bytes_due.push_back('{out_byte: b, frame_last: (parser.left == 32'd0),
                                   frame_length: parser.length});
        if (parser.left == 32'd0) parser.phase = PhHunt;
      end
      PhSkip: begin
        parser.left = parser.left - 32'd1;
        if (parser.left == 32'd0) parser.phase = PhHunt;
      end
      default: begin
        if (clast) parser.phase = PhHunt;
      end
    endcase
  endfunction

  // stimulus building blocks
  task automatic send_byte(input logic [7:0] b, input logic last, input logic counted);
    stream_backlog.push_back('{data_byte: b, chunk_last: last, drain_first: pause_before_next});
    pause_before_next = 1'b0;
    if (counted) stream_count++;
  endtask

  task automatic send_header(input logic [31:0] len, input logic last4, input logic marks);
    for (int i = 0; i < 4; i++) begin
      send_byte(len[31-8*i -: 8], (i == 3) ? last4 : (marks && $urandom_range(0, 7) == 0), 1'b1);
    end
  endtask

  task automatic send_frame(input int unsigned len);
    send_header(len, $urandom_range(0, 7) == 0, 1'b1);
    for (int unsigned i = 4; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b1);
    end
  endtask

  // zero length, optionally behind a stray partial header of zero bytes
  task automatic send_zero_frame(input logic last4, input int unsigned stray);
    logic ends_chunk;
    ends_chunk = (stray == 0) && last4;
    repeat (stray) send_byte(8'h00, 1'b0, 1'b1);
    send_header(32'd0, ends_chunk, stray == 0);
    if (!ends_chunk) begin
      // noise that the block drops until the chunk ends
      repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
  endtask

  // sender: bursts and gaps, holds a request until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.data_byte  <= 8'h00;
      in_if.chunk_last <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
      parser = '{shift: 32'd0, count: 3'd0, left: 32'd0, length: 32'd0, phase: PhHunt};
    end else begin
      offering = in_if.valid && !in_if.ready;
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.data_byte, in_if.chunk_last);
        bytes_accepted++;
      end
      if (!offering) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (stream_backlog.size() != 0 &&
                     !(stream_backlog[0].drain_first && kept_bytes_due.size() != 0)) begin
          req_now = stream_backlog.pop_front();
          in_if.data_byte  <= req_now.data_byte;
          in_if.chunk_last <= req_now.chunk_last;
          offering = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
      in_if.valid <= offering;
    end
  end

  // receiver: checks each kept byte, stalls on a rotating pattern plus long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left       = 0;
      next_long_stall = StallEvery;
      pattern_cycle   = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (kept_bytes_due.size() == 0) begin
          $error("unexpected result: out_byte %0h frame_last %0b frame_length %0d",
                 out_if.out_byte, out_if.frame_last, out_if.frame_length);
          error_count++;
        end else begin
          want = kept_bytes_due.pop_front();
          if (out_if.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected %0h, actual %0h", want.out_byte, out_if.out_byte);
            error_count++;
          end
          if (out_if.frame_last !== want.frame_last) begin
            $error("frame_last mismatch: expected %0b, actual %0b",
                   want.frame_last, out_if.frame_last);
            error_count++;
          end
          if (out_if.frame_length !== want.frame_length) begin
            $error("frame_length mismatch: expected %0d, actual %0d",
                   want.frame_length, out_if.frame_length);
            error_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        take = 1'b0;
      end else if (results_seen >= next_long_stall) begin
        // long hold-off so the result queue fills and the input stalls
        hold_left       = LongStall;
        next_long_stall = next_long_stall + StallEvery;
        take            = 1'b0;
      end else begin
        pattern_cycle++;
        case (pattern_cycle[6:5])
          2'd0:    take = 1'b1;
          2'd1:    take = 1'($urandom_range(0, 1));
          2'd2:    take = (pattern_cycle[1:0] == 2'd0);
          default: take = ($urandom_range(0, 3) != 0);
        endcase
      end
      out_if.ready <= take;
    end
  end

  // watchdog on cycles with no request taken on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == IdleLimit) begin
        $display("no progress for %0d cycles", IdleLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;

    // zero length, rest of the chunk dropped
    send_header(32'd0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    // zero length ending the chunk on its own last header byte
    send_header(32'd0, 1'b1, 1'b0);
    // header-only frame and a short length
    send_header(HdrLen, 1'b0, 1'b0);
    send_header(32'd2, 1'b0, 1'b0);
    // smallest kept frame, body extremes, chunk end inside the frame
    send_header(32'd9, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);

    // random frame mix, sender drains now and then
    next_pause = stream_count;
    while (stream_count < StreamTarget) begin
      if (stream_count >= next_pause) begin
        pause_before_next = 1'b1;
        next_pause        = stream_count + PauseEvery;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pick = $urandom_range(0, 49);
        if (pick == 0) send_frame($urandom_range(256, 300));
        else if (pick < 6) send_frame($urandom_range(25, 64));
        else send_frame($urandom_range(9, 24));
      end else if (pick < 70) begin
        send_frame($urandom_range(5, 8));
      end else if (pick < 80) begin
        send_frame($urandom_range(1, 4));
      end else if (pick < 92) begin
        send_zero_frame(1'($urandom_range(0, 1)), 0);
      end else begin
        // broken sequence: stray partial header before a zero length
        send_zero_frame(1'b0, $urandom_range(1, 3));
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stream_backlog.size() != 0 || in_if.valid) @(posedge clk_i);
    while (kept_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("run covered %0d stream bytes and checked %0d kept frame bytes",
             bytes_accepted, results_seen);
    $display("frames seen: %0d kept, %0d consumed, %0d header-only or short, %0d zero-length",
             frames_kept, frames_consumed, frames_short, frames_zero);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_in_if.sv
hw/rtl/lpd_out_if.sv
hw/rtl/length_prefixed_deframer.sv
bench/length_prefixed_deframer_test.sv
